@@ hdl/assert_macros.svh @@
// Assertion helpers for the strip chart checker.
// Each one samples on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define STC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("strip chart check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define STC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("strip chart check failed");

`endif

@@ hdl/stc_pkg.sv @@
package stc_pkg;

  // Plot geometry
  localparam int PLOT_WIDTH  = 256;
  localparam int PLOT_HEIGHT = 128;
  localparam int PLOT_DEPTH  = PLOT_WIDTH * PLOT_HEIGHT;
  localparam int COL_W       = $clog2(PLOT_WIDTH);
  localparam int ROW_W       = $clog2(PLOT_HEIGHT);
  localparam int ADDR_W      = $clog2(PLOT_DEPTH);

  // Beat field widths
  localparam int LEVEL_W = 16;
  localparam int RCOL_W  = 8;
  localparam int RROW_W  = 7;
  localparam int COLOR_W = 8;

  // Configuration port
  localparam int SPC_W      = 16;
  localparam int FI_W       = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_COLUMN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL     = 1'd1;
  localparam logic [SPC_W-1:0]     SPC_RESET              = 16'd100;
  localparam logic [FI_W-1:0]      FI_RESET               = 24'd1000;

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Pixel: bit 0 red, bit 1 green, bit 2 blue
  typedef logic [2:0] pix_t;
  localparam pix_t PIX_BLACK = 3'b000;
  localparam pix_t PIX_RED   = 3'b001;
  localparam pix_t PIX_GREEN = 3'b010;
  localparam pix_t PIX_WHITE = 3'b111;

  localparam logic [COLOR_W-1:0] COLOR_ON  = 8'hFF;
  localparam logic [COLOR_W-1:0] COLOR_OFF = 8'h00;

  // Row mapping arithmetic
  localparam int MAG_W  = LEVEL_W - 1;
  localparam int PROD_W = MAG_W + $clog2(PLOT_HEIGHT) + 1;
  localparam int UP_W   = PROD_W - MAG_W;

  // row = HEIGHT-1-ceil(level*HEIGHT/32768), negatives clamp to 0, saturate at row 0
  function automatic logic [ROW_W-1:0] level_to_row(input logic [LEVEL_W-1:0] level);
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] sum;
    logic [UP_W-1:0]   up;
    mag = level[LEVEL_W-1] ? '0 : level[MAG_W-1:0];
    sum = PROD_W'(mag) * PROD_W'(PLOT_HEIGHT) + PROD_W'((1 << MAG_W) - 1);
    up  = sum[PROD_W-1:MAG_W];
    if (up >= UP_W'(PLOT_HEIGHT)) begin
      return '0;
    end
    return ROW_W'(UP_W'(PLOT_HEIGHT - 1) - up);
  endfunction

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] row);
    return ADDR_W'(row) * ADDR_W'(PLOT_WIDTH) + ADDR_W'(col);
  endfunction

  function automatic logic [COLOR_W-1:0] to_color(input logic on);
    return on ? COLOR_ON : COLOR_OFF;
  endfunction

endpackage

@@ hdl/stc_in_if.sv @@
interface stc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic signed [stc_pkg::LEVEL_W-1:0]  left_level;
  logic signed [stc_pkg::LEVEL_W-1:0]  right_level;
  logic        [stc_pkg::RCOL_W-1:0]   read_column;
  logic        [stc_pkg::RROW_W-1:0]   read_row;

  modport source(output valid, operation, left_level, right_level, read_column, read_row,
                 input ready);
  modport sink(input valid, operation, left_level, right_level, read_column, read_row,
               output ready);
endinterface

@@ hdl/stc_out_if.sv @@
interface stc_out_if;
  logic                          valid;
  logic                          ready;
  logic [stc_pkg::COLOR_W-1:0]   red_value;
  logic [stc_pkg::COLOR_W-1:0]   green_value;
  logic [stc_pkg::COLOR_W-1:0]   blue_value;
  logic                          frame_ready;

  modport source(output valid, red_value, green_value, blue_value, frame_ready,
                 input ready);
  modport sink(input valid, red_value, green_value, blue_value, frame_ready,
               output ready);
endinterface

@@ hdl/scrolling_two_channel_strip_chart.sv @@
// Two-channel scrolling strip chart. Each input beat either adds a sample pair (plot a red
// point for the left Q15 level and a green point for the right level in the newest column,
// scroll by one column every samples_per_column samples, flag frame_ready every
// frame_interval samples) or reads one displayed pixel, column 0 being the oldest. Every
// input beat gives exactly one result beat; sample beats return black color bytes, read
// beats return 0 or 255 per channel and frame_ready 0. The pixel store is one 3-bit-wide
// synchronous RAM of PLOT_WIDTH*PLOT_HEIGHT entries, and the block works on one beat at a
// time: a read runs through ST_READ, ST_READ_D and ST_DONE, a sample through ST_PLOT_L,
// ST_PLOT_R, ST_PLOT_W and ST_DONE; the result register loads as ST_DONE is left, and
// the next beat is taken in ST_IDLE. A sample that scrolls also runs ST_CLEAR, which
// clears the new newest column with one RAM write per cycle. The two read-modify-writes
// of a sample share the single RAM read port. While the result register still holds an
// untaken beat, the block still takes and works on the next beat but holds its result
// in ST_DONE. No clearing pass runs after reset: a per-column flag marks columns never
// cleared since reset, and those read as white. Configuration writes on cfg_we take
// effect at once and are meant for idle periods.
module scrolling_two_channel_strip_chart (
  input  logic                               clk,
  input  logic                               rst_n,
  stc_in_if.sink                             in_ch,
  stc_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLOT_L,   // issue read of the left point
    ST_PLOT_R,   // write left point, issue read of the right point
    ST_PLOT_W,   // write right point
    ST_CLEAR,    // sweep the new newest column to black
    ST_READ,     // issue read of the requested pixel
    ST_READ_D,   // pick up the pixel
    ST_DONE      // hand the result to the output register
  } state_t;

  // Control state
  state_t                            state_r, state_nxt;
  logic [stc_pkg::SPC_W-1:0]         spc_r, spc_nxt;
  logic [stc_pkg::FI_W-1:0]          fi_r, fi_nxt;
  logic [stc_pkg::COL_W-1:0]         offset_r, offset_nxt;
  logic [stc_pkg::SPC_W-1:0]         col_cd_r, col_cd_nxt;
  logic [stc_pkg::FI_W-1:0]          frame_cd_r, frame_cd_nxt;
  logic [stc_pkg::PLOT_WIDTH-1:0]    col_valid_r, col_valid_nxt;
  logic                              out_valid_r, out_valid_nxt;

  // Per-beat working registers
  logic                              clear_pend_r, clear_pend_nxt;
  logic [stc_pkg::COL_W-1:0]         plot_col_r, plot_col_nxt;
  logic [stc_pkg::COL_W-1:0]         clr_col_r, clr_col_nxt;
  logic [stc_pkg::ROW_W-1:0]         clr_row_r, clr_row_nxt;
  logic [stc_pkg::ROW_W-1:0]         lrow_r, lrow_nxt;
  logic [stc_pkg::ROW_W-1:0]         rrow_r, rrow_nxt;
  logic [stc_pkg::COL_W-1:0]         rd_col_r, rd_col_nxt;
  logic [stc_pkg::ROW_W-1:0]         rd_row_r, rd_row_nxt;
  logic                              rd_in_range_r, rd_in_range_nxt;
  stc_pkg::pix_t                     fwd_r, fwd_nxt;
  stc_pkg::pix_t                     res_pix_r, res_pix_nxt;
  logic                              res_frame_r, res_frame_nxt;
  stc_pkg::pix_t                     out_pix_r, out_pix_nxt;
  logic                              out_frame_r, out_frame_nxt;

  // Pixel store
  stc_pkg::pix_t                     mem [stc_pkg::PLOT_DEPTH];
  stc_pkg::pix_t                     mem_rdata_r;
  logic [stc_pkg::ADDR_W-1:0]        mem_raddr;
  logic [stc_pkg::ADDR_W-1:0]        mem_waddr;
  stc_pkg::pix_t                     mem_wdata;
  logic                              mem_we;

  logic                              in_fire;
  logic                              out_free;
  logic [stc_pkg::COL_W:0]           rd_sum;
  stc_pkg::pix_t                     old_r_pix;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign out_free           = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.red_value   = stc_pkg::to_color(out_pix_r[0]);
  assign out_ch.green_value = stc_pkg::to_color(out_pix_r[1]);
  assign out_ch.blue_value  = stc_pkg::to_color(out_pix_r[2]);
  assign out_ch.frame_ready = out_frame_r;

  // Rotated read column, (read_column + offset) mod PLOT_WIDTH
  assign rd_sum = (stc_pkg::COL_W+1)'(stc_pkg::COL_W'(in_ch.read_column))
                + (stc_pkg::COL_W+1)'(offset_r);

  // Right point sees the left write when both land on the same row
  assign old_r_pix = (lrow_r == rrow_r) ? fwd_r : mem_rdata_r;

  always_comb begin
    state_nxt       = state_r;
    spc_nxt         = spc_r;
    fi_nxt          = fi_r;
    offset_nxt      = offset_r;
    col_cd_nxt      = col_cd_r;
    frame_cd_nxt    = frame_cd_r;
    col_valid_nxt   = col_valid_r;
    out_valid_nxt   = out_valid_r;
    clear_pend_nxt  = clear_pend_r;
    plot_col_nxt    = plot_col_r;
    clr_col_nxt     = clr_col_r;
    clr_row_nxt     = clr_row_r;
    lrow_nxt        = lrow_r;
    rrow_nxt        = rrow_r;
    rd_col_nxt      = rd_col_r;
    rd_row_nxt      = rd_row_r;
    rd_in_range_nxt = rd_in_range_r;
    fwd_nxt         = fwd_r;
    res_pix_nxt     = res_pix_r;
    res_frame_nxt   = res_frame_r;
    out_pix_nxt     = out_pix_r;
    out_frame_nxt   = out_frame_r;
    mem_raddr       = stc_pkg::pix_addr(plot_col_r, lrow_r);
    mem_waddr       = stc_pkg::pix_addr(plot_col_r, lrow_r);
    mem_wdata       = stc_pkg::PIX_BLACK;
    mem_we          = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        stc_pkg::CFG_SAMPLES_PER_COLUMN: spc_nxt = cfg_data[stc_pkg::SPC_W-1:0];
        stc_pkg::CFG_FRAME_INTERVAL:     fi_nxt  = cfg_data[stc_pkg::FI_W-1:0];
        default: ;
      endcase
    end

    // Drop the result beat once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.operation == stc_pkg::OP_READ) begin
            rd_col_nxt      = (rd_sum >= (stc_pkg::COL_W+1)'(stc_pkg::PLOT_WIDTH))
                            ? stc_pkg::COL_W'(rd_sum - (stc_pkg::COL_W+1)'(stc_pkg::PLOT_WIDTH))
                            : stc_pkg::COL_W'(rd_sum);
            rd_row_nxt      = stc_pkg::ROW_W'(in_ch.read_row);
            rd_in_range_nxt = (32'(in_ch.read_column) < stc_pkg::PLOT_WIDTH)
                           && (32'(in_ch.read_row) < stc_pkg::PLOT_HEIGHT);
            res_frame_nxt   = 1'b0;
            state_nxt       = ST_READ;
          end else begin
            lrow_nxt     = stc_pkg::level_to_row(in_ch.left_level);
            rrow_nxt     = stc_pkg::level_to_row(in_ch.right_level);
            // Newest column is one behind the offset
            plot_col_nxt = (offset_r == '0) ? stc_pkg::COL_W'(stc_pkg::PLOT_WIDTH - 1)
                                            : offset_r - 1'b1;
            res_pix_nxt  = stc_pkg::PIX_BLACK;
            // Scroll: the column that becomes newest is the one at the old offset
            clear_pend_nxt = (col_cd_r == '0);
            clr_col_nxt    = offset_r;
            clr_row_nxt    = '0;
            if (col_cd_r == '0) begin
              offset_nxt              = (offset_r == stc_pkg::COL_W'(stc_pkg::PLOT_WIDTH - 1))
                                      ? '0 : offset_r + 1'b1;
              col_cd_nxt              = spc_r - 1'b1;
              col_valid_nxt[offset_r] = 1'b1;
            end else begin
              col_cd_nxt = col_cd_r - 1'b1;
            end
            if (frame_cd_r == '0) begin
              frame_cd_nxt  = fi_r - 1'b1;
              res_frame_nxt = 1'b1;
            end else begin
              frame_cd_nxt  = frame_cd_r - 1'b1;
              res_frame_nxt = 1'b0;
            end
            state_nxt = ST_PLOT_L;
          end
        end
      end
      ST_PLOT_L: begin
        mem_raddr = stc_pkg::pix_addr(plot_col_r, lrow_r);
        state_nxt = ST_PLOT_R;
      end
      ST_PLOT_R: begin
        // A never-cleared column stays white, so skip the write
        mem_waddr = stc_pkg::pix_addr(plot_col_r, lrow_r);
        mem_wdata = mem_rdata_r | stc_pkg::PIX_RED;
        mem_we    = col_valid_r[plot_col_r];
        fwd_nxt   = mem_rdata_r | stc_pkg::PIX_RED;
        mem_raddr = stc_pkg::pix_addr(plot_col_r, rrow_r);
        state_nxt = ST_PLOT_W;
      end
      ST_PLOT_W: begin
        mem_waddr = stc_pkg::pix_addr(plot_col_r, rrow_r);
        mem_wdata = old_r_pix | stc_pkg::PIX_GREEN;
        mem_we    = col_valid_r[plot_col_r];
        state_nxt = clear_pend_r ? ST_CLEAR : ST_DONE;
      end
      ST_CLEAR: begin
        mem_waddr   = stc_pkg::pix_addr(clr_col_r, clr_row_r);
        mem_wdata   = stc_pkg::PIX_BLACK;
        mem_we      = 1'b1;
        clr_row_nxt = clr_row_r + 1'b1;
        if (clr_row_r == stc_pkg::ROW_W'(stc_pkg::PLOT_HEIGHT - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        mem_raddr = stc_pkg::pix_addr(rd_col_r, rd_row_r);
        state_nxt = ST_READ_D;
      end
      ST_READ_D: begin
        if (!rd_in_range_r) begin
          res_pix_nxt = stc_pkg::PIX_BLACK;
        end else if (!col_valid_r[rd_col_r]) begin
          res_pix_nxt = stc_pkg::PIX_WHITE;
        end else begin
          res_pix_nxt = mem_rdata_r;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = res_pix_r;
          out_frame_nxt = res_frame_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      spc_r       <= stc_pkg::SPC_RESET;
      fi_r        <= stc_pkg::FI_RESET;
      offset_r    <= '0;
      col_cd_r    <= '0;
      frame_cd_r  <= '0;
      col_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      spc_r       <= spc_nxt;
      fi_r        <= fi_nxt;
      offset_r    <= offset_nxt;
      col_cd_r    <= col_cd_nxt;
      frame_cd_r  <= frame_cd_nxt;
      col_valid_r <= col_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    clear_pend_r  <= clear_pend_nxt;
    plot_col_r    <= plot_col_nxt;
    clr_col_r     <= clr_col_nxt;
    clr_row_r     <= clr_row_nxt;
    lrow_r        <= lrow_nxt;
    rrow_r        <= rrow_nxt;
    rd_col_r      <= rd_col_nxt;
    rd_row_r      <= rd_row_nxt;
    rd_in_range_r <= rd_in_range_nxt;
    fwd_r         <= fwd_nxt;
    res_pix_r     <= res_pix_nxt;
    res_frame_r   <= res_frame_nxt;
    out_pix_r     <= out_pix_nxt;
    out_frame_r   <= out_frame_nxt;
  end

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

endmodule

@@ hdl/stc_checker.sv @@
`include "assert_macros.svh"

module stc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [stc_pkg::COLOR_W-1:0]   red_value,
  input logic [stc_pkg::COLOR_W-1:0]   green_value,
  input logic [stc_pkg::COLOR_W-1:0]   blue_value,
  input logic                          frame_ready
);

  logic colors_black;
  logic colors_binary;

  assign colors_black  = (red_value == stc_pkg::COLOR_OFF)
                      && (green_value == stc_pkg::COLOR_OFF)
                      && (blue_value == stc_pkg::COLOR_OFF);
  assign colors_binary = ((red_value == stc_pkg::COLOR_OFF)
                       || (red_value == stc_pkg::COLOR_ON))
                      && ((green_value == stc_pkg::COLOR_OFF)
                       || (green_value == stc_pkg::COLOR_ON))
                      && ((blue_value == stc_pkg::COLOR_OFF)
                       || (blue_value == stc_pkg::COLOR_ON));

  // A frame flag only comes with a sample beat, whose colors are black
  `STC_ASSERT_IMP(a_frame_black, out_valid && frame_ready, colors_black)

  // Color bytes are all-off or all-on
  `STC_ASSERT_IMP(a_color_levels, out_valid, colors_binary)

  // One beat at a time: no accept in the cycle after an accept
  `STC_ASSERT_NXT(a_one_beat, in_valid && in_ready, !in_ready)

  // A stalled result beat stays offered
  `STC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

bind scrolling_two_channel_strip_chart stc_checker u_stc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .red_value   (out_ch.red_value),
  .green_value (out_ch.green_value),
  .blue_value  (out_ch.blue_value),
  .frame_ready (out_ch.frame_ready)
);
